>>> rtl/core/mbdi_pkg.sv
package mbdi_pkg;

    // Field and datapath widths
    localparam int POSITION_BITS = 16;
    localparam int BLOCK_W       = 16;
    localparam int OFFSET_W      = 14;
    localparam int COUNT_W       = 16;
    localparam int STATE_W       = 64;
    localparam int DRAW_W        = 63;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    // Divider step counter width, one step per quotient bit
    localparam int DIV_CNT_W     = $clog2(POSITION_BITS + 1);

    // Scatter offset span and the widths that follow from it
    localparam int OFFSET_SPAN = 10000;
    localparam int SPAN_W      = $clog2(OFFSET_SPAN + 1);
    localparam int SPAN_IDX_W  = (SPAN_W > 1) ? $clog2(SPAN_W) : 1;
    localparam int PROD_W      = DRAW_W + SPAN_W;
    localparam logic [SPAN_W-1:0] SPAN_VEC = SPAN_W'(OFFSET_SPAN);

    // Generator and threshold constants
    localparam logic [STATE_W-1:0] SEED_RESET   = 64'd88172645463325252;
    localparam logic [DRAW_W-1:0]  Q63_MASK     = {DRAW_W{1'b1}};
    localparam logic [DRAW_W-1:0]  WRONG_RESET  = 63'd9223372036854776;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic [BLOCK_W-1:0] BLOCK_RESET  = 16'd256;

    // Opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_OFFSET = 2'd1;
    localparam logic [1:0] OP_BIT    = 2'd2;

    // Model modes
    localparam logic MODE_GROUND = 1'b0;
    localparam logic MODE_SIMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRONG_DIR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_POL_EN    = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic               source_bit;
        logic [BLOCK_W-1:0] bit_position;
        logic               component_end;
    } item_t;

    typedef struct packed {
        logic                result_bit;
        logic                bit_known;
        logic                bit_flipped;
        logic                polarity_out;
        logic [OFFSET_W-1:0] offset_out;
        logic [COUNT_W-1:0]  flipped_total;
        logic [COUNT_W-1:0]  known_total;
    } result_t;

endpackage

>>> rtl/core/mbdi_xorshift.sv
// xorshift64 generator: one 13/7/17 step per cycle on request
module mbdi_xorshift
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [mbdi_pkg::STATE_W-1:0]  seed,
    input  logic                          step,
    output logic [mbdi_pkg::STATE_W-1:0]  state
);

    logic [mbdi_pkg::STATE_W-1:0] state_reg;
    logic [mbdi_pkg::STATE_W-1:0] state_next;
    logic [mbdi_pkg::STATE_W-1:0] s1;
    logic [mbdi_pkg::STATE_W-1:0] s2;
    logic [mbdi_pkg::STATE_W-1:0] s3;

    // One generator step
    always_comb
    begin
        s1 = state_reg ^ (state_reg << 13);
        s2 = s1 ^ (s1 >> 7);
        s3 = s2 ^ (s2 << 17);
        state_next = state_reg;
        if (load)
        begin
            state_next = seed;
        end
        else if (step)
        begin
            state_next = s3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbdi_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

>>> rtl/core/mbdi_divider.sv
// Restoring divider: one quotient bit per cycle
module mbdi_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mbdi_pkg::POSITION_BITS-1:0]  dividend,
    input  logic [mbdi_pkg::BLOCK_W-1:0]        divisor,
    output logic                                done,
    output logic [mbdi_pkg::POSITION_BITS-1:0]  quotient
);

    logic [mbdi_pkg::POSITION_BITS-1:0] quo_reg;
    logic [mbdi_pkg::POSITION_BITS-1:0] quo_next;
    logic [mbdi_pkg::BLOCK_W-1:0]       rem_reg;
    logic [mbdi_pkg::BLOCK_W-1:0]       rem_next;
    logic [mbdi_pkg::BLOCK_W-1:0]       div_reg;
    logic [mbdi_pkg::BLOCK_W-1:0]       div_next;
    logic [mbdi_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [mbdi_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [mbdi_pkg::BLOCK_W:0]         trial;
    logic [mbdi_pkg::BLOCK_W:0]         diff;
    logic                               ge;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial     = {rem_reg, quo_reg[mbdi_pkg::POSITION_BITS-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = mbdi_pkg::DIV_CNT_W'(mbdi_pkg::POSITION_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[mbdi_pkg::POSITION_BITS-2:0], ge};
            rem_next = ge ? diff[mbdi_pkg::BLOCK_W-1:0] : trial[mbdi_pkg::BLOCK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mbdi_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/mbdi_offset_scaler.sv
// Scatter offset: floor(r * span / (2^63 - 1)) by shift-add, then one correction step
module mbdi_offset_scaler
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [mbdi_pkg::DRAW_W-1:0]         draw,
    output logic                                done,
    output logic [mbdi_pkg::OFFSET_W-1:0]       offset
);

    logic [mbdi_pkg::DRAW_W-1:0]     mcand_reg;
    logic [mbdi_pkg::DRAW_W-1:0]     mcand_next;
    logic [mbdi_pkg::PROD_W-1:0]     acc_reg;
    logic [mbdi_pkg::PROD_W-1:0]     acc_next;
    logic [mbdi_pkg::SPAN_IDX_W-1:0] cnt_reg;
    logic [mbdi_pkg::SPAN_IDX_W-1:0] cnt_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            fix_reg;
    logic                            fix_next;
    logic                            done_reg;
    logic                            done_next;
    logic [mbdi_pkg::SPAN_W:0]       q_reg;
    logic [mbdi_pkg::SPAN_W:0]       q_next;
    logic [mbdi_pkg::SPAN_W-1:0]     hi;
    logic [mbdi_pkg::DRAW_W:0]       lo_sum;

    // P = a * 2^63 + b = a * (2^63 - 1) + (a + b), with a + b below twice the divisor
    always_comb
    begin
        hi         = acc_reg[mbdi_pkg::PROD_W-1:mbdi_pkg::DRAW_W];
        lo_sum     = {1'b0, acc_reg[mbdi_pkg::DRAW_W-1:0]}
                   + (mbdi_pkg::DRAW_W + 1)'(hi);
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        fix_next   = 1'b0;
        done_next  = 1'b0;
        q_next     = q_reg;
        if (start)
        begin
            mcand_next = draw;
            acc_next   = '0;
            cnt_next   = mbdi_pkg::SPAN_IDX_W'(mbdi_pkg::SPAN_W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << 1)
                     + (mbdi_pkg::SPAN_VEC[cnt_reg] ? mbdi_pkg::PROD_W'(mcand_reg)
                                                    : '0);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (fix_reg)
        begin
            q_next    = (mbdi_pkg::SPAN_W + 1)'(hi)
                      + ((lo_sum >= {1'b0, mbdi_pkg::Q63_MASK}) ? 1'b1 : 1'b0);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        q_reg     <= q_next;
    end

    assign done   = done_reg;
    assign offset = mbdi_pkg::OFFSET_W'(q_reg);

endmodule

>>> rtl/core/memory_bit_decay_injector_unit.sv
// Sequence from transfer in to result valid: a ground-mode bit runs the divider for the
// block index, then draw, compare, finish; a simple-mode bit takes one or two draws; an
// offset draw runs the 14-step shift-add multiplier plus one correction step; start makes
// one draw or goes straight to finish, and an idle opcode goes to finish. One item at a time:
// the next transfer is taken the cycle after the result is registered.
// Reset (async, active low) loads register defaults, the default seed and clears counters.
module memory_bit_decay_injector_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  mbdi_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output mbdi_pkg::result_t                     result,
    input  logic                                  wr_en,
    input  logic [mbdi_pkg::CFG_INDEX_W-1:0]      wr_index,
    input  logic [mbdi_pkg::CFG_DATA_W-1:0]       wr_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_DRAW = 6'b000100,
        ST_CMP  = 6'b001000,
        ST_MUL  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Configuration registers
    logic                              mode_reg;
    logic [mbdi_pkg::STATE_W-1:0]      seed_reg;
    logic [mbdi_pkg::DRAW_W-1:0]       decay_reg;
    logic [mbdi_pkg::DRAW_W-1:0]       wrong_reg;
    logic [mbdi_pkg::DRAW_W-1:0]       keep_reg;
    logic [mbdi_pkg::DRAW_W-1:0]       error_reg;
    logic [mbdi_pkg::BLOCK_W-1:0]      block_reg;
    logic                              pol_en_reg;

    // Sequencer and working state
    state_t                            state_reg;
    state_t                            state_next;
    mbdi_pkg::item_t                   item_reg;
    mbdi_pkg::item_t                   item_next;
    logic                              pol_reg;
    logic                              pol_next;
    logic [mbdi_pkg::COUNT_W-1:0]      flip_cnt_reg;
    logic [mbdi_pkg::COUNT_W-1:0]      flip_cnt_next;
    logic [mbdi_pkg::COUNT_W-1:0]      known_cnt_reg;
    logic [mbdi_pkg::COUNT_W-1:0]      known_cnt_next;
    logic                              res_reg;
    logic                              res_next;
    logic                              known_reg;
    logic                              known_next;
    logic                              gs_reg;
    logic                              gs_next;
    logic                              second_reg;
    logic                              second_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    mbdi_pkg::result_t                 out_reg;
    mbdi_pkg::result_t                 out_next;

    // Shared unit controls
    logic                              gen_load;
    logic                              gen_step;
    logic [mbdi_pkg::STATE_W-1:0]      gen_seed;
    logic [mbdi_pkg::STATE_W-1:0]      gen_state;
    logic [mbdi_pkg::DRAW_W-1:0]       draw_r;
    logic                              div_start;
    logic                              div_done;
    logic [mbdi_pkg::POSITION_BITS-1:0] div_q;
    logic [mbdi_pkg::BLOCK_W-1:0]      divisor;
    logic                              mul_start;
    logic                              mul_done;
    logic [mbdi_pkg::OFFSET_W-1:0]     mul_offset;
    logic [mbdi_pkg::DRAW_W-1:0]       thr;
    logic                              hit;
    logic                              is_bit;
    logic                              flipped;
    logic [mbdi_pkg::COUNT_W-1:0]      flip_sum;
    logic [mbdi_pkg::COUNT_W-1:0]      known_sum;

    assign draw_r   = gen_state[mbdi_pkg::DRAW_W-1:0];
    assign gen_seed = (seed_reg != '0) ? seed_reg : mbdi_pkg::SEED_RESET;
    assign divisor  = (block_reg != '0) ? block_reg : mbdi_pkg::BLOCK_W'(1);

    mbdi_xorshift u_gen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (gen_load),
        .seed  (gen_seed),
        .step  (gen_step),
        .state (gen_state)
    );

    mbdi_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mbdi_pkg::POSITION_BITS'(item.bit_position)),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    mbdi_offset_scaler u_scale
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .draw   (draw_r),
        .done   (mul_done),
        .offset (mul_offset)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mbdi_pkg::MODE_GROUND;
            seed_reg   <= mbdi_pkg::SEED_RESET;
            decay_reg  <= '0;
            wrong_reg  <= mbdi_pkg::WRONG_RESET;
            keep_reg   <= '0;
            error_reg  <= '0;
            block_reg  <= mbdi_pkg::BLOCK_RESET;
            pol_en_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mbdi_pkg::REG_MODE:      mode_reg   <= wr_data[0];
                mbdi_pkg::REG_SEED:      seed_reg   <= wr_data;
                mbdi_pkg::REG_DECAY:     decay_reg  <= wr_data[mbdi_pkg::DRAW_W-1:0];
                mbdi_pkg::REG_WRONG_DIR: wrong_reg  <= wr_data[mbdi_pkg::DRAW_W-1:0];
                mbdi_pkg::REG_KEEP:      keep_reg   <= wr_data[mbdi_pkg::DRAW_W-1:0];
                mbdi_pkg::REG_ERROR:     error_reg  <= wr_data[mbdi_pkg::DRAW_W-1:0];
                mbdi_pkg::REG_BLOCK:     block_reg  <= wr_data[mbdi_pkg::BLOCK_W-1:0];
                mbdi_pkg::REG_POL_EN:    pol_en_reg <= wr_data[0];
                default:                 ;
            endcase
        end
    end

    // Threshold for the current draw and the compare
    always_comb
    begin
        if (mode_reg == mbdi_pkg::MODE_GROUND)
        begin
            thr = (item_reg.source_bit != gs_reg) ? decay_reg : wrong_reg;
        end
        else
        begin
            thr = second_reg ? error_reg : keep_reg;
        end
        hit = (draw_r < thr);
    end

    // Result fields and saturating counters
    always_comb
    begin
        is_bit    = (item_reg.opcode == mbdi_pkg::OP_BIT);
        flipped   = is_bit & (res_reg ^ item_reg.source_bit);
        flip_sum  = flip_cnt_reg
                  + ((flipped && flip_cnt_reg != mbdi_pkg::COUNT_MAX) ? 1'b1 : 1'b0);
        known_sum = known_cnt_reg
                  + ((known_reg && known_cnt_reg != mbdi_pkg::COUNT_MAX) ? 1'b1 : 1'b0);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pol_next       = pol_reg;
        flip_cnt_next  = flip_cnt_reg;
        known_cnt_next = known_cnt_reg;
        res_next       = res_reg;
        known_next     = known_reg;
        gs_next        = gs_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        gen_load       = 1'b0;
        gen_step       = 1'b0;
        div_start      = 1'b0;
        mul_start      = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next   = item;
                    res_next    = 1'b0;
                    known_next  = 1'b0;
                    second_next = 1'b0;
                    case (item.opcode)
                        mbdi_pkg::OP_START:
                        begin
                            gen_load = 1'b1;
                            pol_next = 1'b0;
                            if (mode_reg == mbdi_pkg::MODE_GROUND && pol_en_reg)
                            begin
                                state_next = ST_DRAW;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        mbdi_pkg::OP_OFFSET:
                        begin
                            state_next = ST_DRAW;
                        end
                        mbdi_pkg::OP_BIT:
                        begin
                            res_next = item.source_bit;
                            if (mode_reg == mbdi_pkg::MODE_GROUND)
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_DRAW;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                // ground state is the block index parity plus the held polarity
                if (div_done)
                begin
                    gs_next    = div_q[0] ^ pol_reg;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                gen_step   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                case (item_reg.opcode)
                    mbdi_pkg::OP_START:
                    begin
                        pol_next   = ~draw_r[mbdi_pkg::DRAW_W-1];
                        state_next = ST_FIN;
                    end
                    mbdi_pkg::OP_OFFSET:
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end
                    mbdi_pkg::OP_BIT:
                    begin
                        if (mode_reg == mbdi_pkg::MODE_GROUND)
                        begin
                            // either direction of a hit inverts the source bit
                            res_next   = hit ? ~item_reg.source_bit : item_reg.source_bit;
                            known_next = (hit ? ~item_reg.source_bit : item_reg.source_bit)
                                       ^ gs_reg;
                            state_next = ST_FIN;
                        end
                        else if (!second_reg)
                        begin
                            if (hit)
                            begin
                                known_next  = 1'b1;
                                second_next = 1'b1;
                                state_next  = ST_DRAW;
                            end
                            else
                            begin
                                state_next = ST_FIN;
                            end
                        end
                        else
                        begin
                            if (hit)
                            begin
                                res_next = ~item_reg.source_bit;
                            end
                            state_next = ST_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // load the output register once it is free
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.result_bit   = res_reg;
                    out_next.bit_known    = known_reg;
                    out_next.bit_flipped  = flipped;
                    out_next.polarity_out = pol_reg;
                    out_next.offset_out   = (item_reg.opcode == mbdi_pkg::OP_OFFSET)
                                          ? mul_offset : '0;
                    if (item_reg.opcode == mbdi_pkg::OP_START)
                    begin
                        out_next.flipped_total = '0;
                        out_next.known_total   = '0;
                        flip_cnt_next          = '0;
                        known_cnt_next         = '0;
                    end
                    else if (is_bit)
                    begin
                        out_next.flipped_total = flip_sum;
                        out_next.known_total   = known_sum;
                        flip_cnt_next  = item_reg.component_end ? '0 : flip_sum;
                        known_cnt_next = item_reg.component_end ? '0 : known_sum;
                    end
                    else
                    begin
                        out_next.flipped_total = flip_cnt_reg;
                        out_next.known_total   = known_cnt_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pol_reg       <= 1'b0;
            flip_cnt_reg  <= '0;
            known_cnt_reg <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pol_reg       <= pol_next;
            flip_cnt_reg  <= flip_cnt_next;
            known_cnt_reg <= known_cnt_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        known_reg <= known_next;
        gs_reg    <= gs_next;
        out_reg   <= out_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
